/* hdl/jpeg_marker_segment_walker_top_defines.svh */
// Assertion macros shared by the marker segment walker RTL.
`ifndef JPEG_MARKER_SEGMENT_WALKER_TOP_DEFINES_SVH
`define JPEG_MARKER_SEGMENT_WALKER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define JMSW_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("jmsw: property violated");
// Condition that must never be true at a clock edge outside reset.
`define JMSW_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("jmsw: forbidden condition seen");
`else
`define JMSW_ASSERT(label, clk, rst_n, prop)
`define JMSW_NEVER(label, clk, rst_n, expr)
`endif
`endif

/* hdl/jmsw_pkg.sv */
// Types and constants shared by the marker segment walker modules.
`default_nettype none
package jmsw_pkg;

	// Marker codes and prefix.
	localparam logic [7:0] MK_PREFIX    = 8'hFF;
	localparam logic [7:0] MK_SOI       = 8'hD8;
	localparam logic [7:0] MK_TEM       = 8'h01;
	localparam logic [7:0] MK_RST_FIRST = 8'hD0;
	localparam logic [7:0] MK_RST_LAST  = 8'hD7;
	localparam logic [7:0] MK_SOS       = 8'hDA;
	localparam logic [7:0] MK_EOI       = 8'hD9;
	localparam logic [7:0] TARGET_RESET = 8'hE2;

	// Smallest file that can hold a marker walk.
	localparam logic [31:0] MIN_FILE_LEN = 32'd4;

	// Register map index.
	typedef enum logic [1:0] {
		REG_FILE_LEN   = 2'd0,
		REG_TARGET     = 2'd1,
		REG_SIG_WORD   = 2'd2,
		REG_SIG_LENGTH = 2'd3
	} reg_idx_t;

	// Per-byte result status.
	typedef enum logic [2:0] {
		ST_STRUCT  = 3'd0,
		ST_PAYLOAD = 3'd1,
		ST_END     = 3'd2,
		ST_BAD     = 3'd3,
		ST_IGNORED = 3'd4
	} status_t;

	// Class of a byte if it turns out to be a marker code.
	typedef enum logic [1:0] {
		CLS_STANDALONE = 2'd0,
		CLS_STOP       = 2'd1,
		CLS_SEGMENT    = 2'd2
	} code_cls_t;

	// Configuration seen by the walker.
	typedef struct packed {
		logic [31:0] file_len;
		logic [7:0]  target_marker;
		logic [31:0] signature_word;
		logic [2:0]  signature_length;
	} cfg_t;

	// Classified item passed from the front to the back.
	typedef struct packed {
		logic [7:0]  data_byte;
		logic        first;
		logic [31:0] pos;
		logic [31:0] pos_next;
		logic        prefix_short;
		code_cls_t   code_cls;
	} item_t;

endpackage
`default_nettype wire

/* hdl/jpeg_marker_segment_walker_top.sv */
// Top level of the JPEG marker segment walker with its register port.
// An accepted byte passes through the two-entry queue and then the result register.
// Throughput: one byte per cycle while the result is not stalled; the walk state updates once per byte.
// With the result stalled, the two-entry queue takes bytes until it holds two, then stalls the input.
// Reset clears the walk, the queue and the result valid flag, and returns
// the registers to file length 0, target marker 0xE2 and an empty signature.
`default_nettype none
module jpeg_marker_segment_walker_top #(
	parameter int SIGNATURE_BYTES = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  data_byte,
	input  wire logic        first_of_file,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [2:0]       status,
	output logic [7:0]       marker_code,
	output logic [7:0]       byte_value,
	output logic [31:0]      byte_offset,
	output logic             segment_last,
	output logic             found_payload,
	output logic [31:0]      found_start_offset
);
	import jmsw_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t reg_idx;
	logic     cfg_wr;
	item_t    front_item;
	item_t    head_item;
	logic     push;
	logic     fifo_full;
	logic     head_valid;
	logic     pop;

	// Register access decode.
	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[3:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_comb begin
		case (reg_idx)
			REG_FILE_LEN:   prdata = cfg_q.file_len;
			REG_TARGET:     prdata = {24'd0, cfg_q.target_marker};
			REG_SIG_WORD:   prdata = cfg_q.signature_word;
			REG_SIG_LENGTH: prdata = {29'd0, cfg_q.signature_length};
			default:        prdata = '0;
		endcase
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.file_len         <= '0;
			cfg_q.target_marker    <= TARGET_RESET;
			cfg_q.signature_word   <= '0;
			cfg_q.signature_length <= '0;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_FILE_LEN:   cfg_q.file_len         <= pwdata;
				REG_TARGET:     cfg_q.target_marker    <= pwdata[7:0];
				REG_SIG_WORD:   cfg_q.signature_word   <= pwdata;
				REG_SIG_LENGTH: cfg_q.signature_length <= pwdata[2:0];
				default:        cfg_q.file_len         <= cfg_q.file_len;
			endcase
		end
	end

	assign in_stall = fifo_full;

	jmsw_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.data_byte     (data_byte),
		.first_of_file (first_of_file),
		.file_len      (cfg_q.file_len),
		.item          (front_item),
		.push          (push)
	);

	jmsw_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (front_item),
		.full       (fifo_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_item  (head_item)
	);

	jmsw_back #(
		.SIGNATURE_BYTES (SIGNATURE_BYTES)
	) u_back (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg                (cfg_q),
		.head_valid         (head_valid),
		.head_item          (head_item),
		.pop                (pop),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.status             (status),
		.marker_code        (marker_code),
		.byte_value         (byte_value),
		.byte_offset        (byte_offset),
		.segment_last       (segment_last),
		.found_payload      (found_payload),
		.found_start_offset (found_start_offset)
	);

endmodule
`default_nettype wire

/* hdl/jmsw_front.sv */
// Front end: accepts bytes, tracks file offsets and classifies each byte.
`default_nettype none
module jmsw_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	input  wire logic           in_stall,
	input  wire logic [7:0]     data_byte,
	input  wire logic           first_of_file,
	input  wire logic [31:0]    file_len,
	output jmsw_pkg::item_t     item,
	output logic                push
);
	import jmsw_pkg::*;

	logic [31:0] pos_q;
	logic [31:0] pos;
	logic [31:0] pos_next;
	code_cls_t   cls;

	// A new file restarts the offset count at zero.
	assign pos      = first_of_file ? 32'd0 : pos_q;
	assign pos_next = pos + 32'd1;
	assign push     = in_valid && !in_stall;

	// Classify the byte as a possible marker code.
	always_comb begin
		case (data_byte) inside
			MK_SOI, MK_TEM, [MK_RST_FIRST:MK_RST_LAST]: cls = CLS_STANDALONE;
			MK_SOS, MK_EOI:                               cls = CLS_STOP;
			default:                                      cls = CLS_SEGMENT;
		endcase
	end

	// Build the item, including the short-file check for a marker prefix.
	always_comb begin
		item.data_byte    = data_byte;
		item.first        = first_of_file;
		item.pos          = pos;
		item.pos_next     = pos_next;
		item.prefix_short = ({1'b0, pos} + 33'd4) > {1'b0, file_len};
		item.code_cls     = cls;
	end

	// Offset counter advances on every accepted item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (push) begin
			pos_q <= pos_next;
		end
	end

endmodule
`default_nettype wire

/* hdl/jmsw_fifo.sv */
// Two-entry item queue between the front end and the walker back end.
`default_nettype none
`include "jpeg_marker_segment_walker_top_defines.svh"
module jmsw_fifo (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  jmsw_pkg::item_t     push_item,
	output logic                full,
	input  wire logic           pop,
	output logic                head_valid,
	output jmsw_pkg::item_t     head_item
);
	import jmsw_pkg::*;

	localparam int DEPTH = 2;

	item_t      mem_q [DEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full       = (count_q == 2'(DEPTH));
	assign head_valid = (count_q != 2'd0);
	assign head_item  = mem_q[rd_ptr_q];

	// Storage write.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	`JMSW_NEVER(a_fifo_no_overflow, clk, arst_n, push && full)
	`JMSW_NEVER(a_fifo_no_underflow, clk, arst_n, pop && !head_valid)
	`JMSW_ASSERT(a_fifo_count_range, clk, arst_n, count_q <= 2'(DEPTH))

endmodule
`default_nettype wire

/* hdl/jmsw_back.sv */
// Back end: walks the marker structure and holds the result item register.
`default_nettype none
`include "jpeg_marker_segment_walker_top_defines.svh"
module jmsw_back #(
	parameter int SIGNATURE_BYTES = 4
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  jmsw_pkg::cfg_t      cfg,
	input  wire logic           head_valid,
	input  jmsw_pkg::item_t     head_item,
	output logic                pop,
	output logic                out_valid,
	input  wire logic           out_stall,
	output logic [2:0]          status,
	output logic [7:0]          marker_code,
	output logic [7:0]          byte_value,
	output logic [31:0]         byte_offset,
	output logic                segment_last,
	output logic                found_payload,
	output logic [31:0]         found_start_offset
);
	import jmsw_pkg::*;

	localparam int PW = $clog2(SIGNATURE_BYTES + 1);

	// Walk phase, one-hot.
	typedef enum logic [7:0] {
		PH_SOI_A   = 8'b0000_0001,
		PH_SOI_B   = 8'b0000_0010,
		PH_PREFIX  = 8'b0000_0100,
		PH_CODE    = 8'b0000_1000,
		PH_LEN_HI  = 8'b0001_0000,
		PH_LEN_LO  = 8'b0010_0000,
		PH_PAYLOAD = 8'b0100_0000,
		PH_STOPPED = 8'b1000_0000
	} phase_t;

	phase_t        phase_q, eff_phase, nxt_phase;
	logic [7:0]    marker_q, eff_marker, nxt_marker;
	logic [7:0]    len_hi_q, eff_len_hi, nxt_len_hi;
	logic [15:0]   rem_q, eff_rem, nxt_rem;
	logic [PW-1:0] prog_q, eff_prog, nxt_prog, prog_inc;
	logic          matching_q, eff_matching, nxt_matching;
	logic          found_q, eff_found, nxt_found;
	logic [31:0]   offset_q, eff_offset, nxt_offset;

	logic          out_valid_q;
	status_t       status_q, res_status;
	logic [7:0]    marker_code_q, res_mcode;
	logic [7:0]    byte_value_q;
	logic [31:0]   byte_offset_q;
	logic          segment_last_q, res_last;
	logic          found_payload_q, res_fpay;
	logic [31:0]   found_start_q;

	logic [PW-1:0] sig_n;
	logic [7:0]    sig_bytes [SIGNATURE_BYTES];
	logic [7:0]    sig_sel;
	logic [15:0]   seg_len;
	logic [32:0]   seg_end;
	logic [7:0]    b;

	assign b = head_item.data_byte;

	// Take the next item whenever the result register is free or draining.
	assign pop = head_valid && (!out_valid_q || !out_stall);

	// A first-of-file item sees the walk state as freshly restarted.
	always_comb begin
		if (head_item.first) begin
			eff_phase    = PH_SOI_A;
			eff_marker   = '0;
			eff_len_hi   = '0;
			eff_rem      = '0;
			eff_prog     = '0;
			eff_matching = 1'b0;
			eff_found    = 1'b0;
			eff_offset   = '0;
		end else begin
			eff_phase    = phase_q;
			eff_marker   = marker_q;
			eff_len_hi   = len_hi_q;
			eff_rem      = rem_q;
			eff_prog     = prog_q;
			eff_matching = matching_q;
			eff_found    = found_q;
			eff_offset   = offset_q;
		end
	end

	// Signature bytes, first byte in the most significant used position.
	for (genvar k = 0; k < SIGNATURE_BYTES; k++) begin : g_sig
		localparam int SH = 8 * (SIGNATURE_BYTES - 1 - k);
		if (SH < 32) begin : g_in
			assign sig_bytes[k] = cfg.signature_word[SH +: 8];
		end else begin : g_out
			assign sig_bytes[k] = 8'd0;
		end
	end

	// Effective signature length saturates at the signature capacity.
	always_comb begin
		if (int'(cfg.signature_length) > SIGNATURE_BYTES) begin
			sig_n = PW'(SIGNATURE_BYTES);
		end else begin
			sig_n = PW'(cfg.signature_length);
		end
	end

	// Signature byte expected next.
	always_comb begin
		sig_sel = '0;
		for (int k = 0; k < SIGNATURE_BYTES; k++) begin
			if (eff_prog == PW'(k)) begin
				sig_sel = sig_bytes[k];
			end
		end
	end

	assign prog_inc = eff_prog + PW'(1);
	assign seg_len  = {eff_len_hi, b};
	assign seg_end  = {1'b0, head_item.pos} + {17'd0, seg_len} - 33'd1;

	// Walk step for one item.
	always_comb begin
		nxt_phase    = eff_phase;
		nxt_marker   = eff_marker;
		nxt_len_hi   = eff_len_hi;
		nxt_rem      = eff_rem;
		nxt_prog     = eff_prog;
		nxt_matching = eff_matching;
		nxt_found    = eff_found;
		nxt_offset   = eff_offset;
		res_status   = ST_STRUCT;
		res_mcode    = '0;
		res_last     = 1'b0;
		res_fpay     = 1'b0;
		case (eff_phase)
			PH_SOI_A: begin
				res_mcode = MK_SOI;
				if (cfg.file_len < MIN_FILE_LEN || b != MK_PREFIX) begin
					res_status = ST_BAD;
					nxt_phase  = PH_STOPPED;
				end else begin
					nxt_phase = PH_SOI_B;
				end
			end
			PH_SOI_B: begin
				res_mcode = MK_SOI;
				if (b != MK_SOI) begin
					res_status = ST_BAD;
					nxt_phase  = PH_STOPPED;
				end else begin
					nxt_marker = MK_SOI;
					nxt_phase  = PH_PREFIX;
				end
			end
			PH_PREFIX: begin
				if (head_item.prefix_short || b != MK_PREFIX) begin
					res_status = ST_BAD;
					nxt_phase  = PH_STOPPED;
				end else begin
					nxt_phase = PH_CODE;
				end
			end
			PH_CODE: begin
				nxt_marker = b;
				res_mcode  = b;
				case (head_item.code_cls)
					CLS_STANDALONE: nxt_phase = PH_PREFIX;
					CLS_STOP: begin
						res_status = ST_END;
						nxt_phase  = PH_STOPPED;
					end
					default: nxt_phase = PH_LEN_HI;
				endcase
			end
			PH_LEN_HI: begin
				res_mcode  = eff_marker;
				nxt_len_hi = b;
				nxt_phase  = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				res_mcode = eff_marker;
				if (seg_len < 16'd2 || seg_end > {1'b0, cfg.file_len}) begin
					res_status = ST_BAD;
					nxt_phase  = PH_STOPPED;
				end else begin
					nxt_rem      = seg_len - 16'd2;
					nxt_matching = 1'b0;
					nxt_prog     = '0;
					if (!eff_found && eff_marker == cfg.target_marker) begin
						nxt_matching = 1'b1;
						if (sig_n == '0) begin
							nxt_found  = 1'b1;
							nxt_offset = head_item.pos_next;
						end
					end
					if (seg_len == 16'd2) begin
						nxt_matching = 1'b0;
						nxt_phase    = PH_PREFIX;
					end else begin
						nxt_phase = PH_PAYLOAD;
					end
				end
			end
			PH_PAYLOAD: begin
				res_status = ST_PAYLOAD;
				res_mcode  = eff_marker;
				if (eff_matching) begin
					if (eff_prog < sig_n) begin
						if (b != sig_sel) begin
							nxt_matching = 1'b0;
						end else begin
							nxt_prog = prog_inc;
							if (prog_inc == sig_n) begin
								nxt_found  = 1'b1;
								nxt_offset = head_item.pos_next;
							end
						end
					end else begin
						res_fpay = 1'b1;
					end
				end
				nxt_rem = eff_rem - 16'd1;
				if (eff_rem == 16'd1) begin
					res_last     = 1'b1;
					nxt_matching = 1'b0;
					nxt_phase    = PH_PREFIX;
				end
			end
			default: begin
				res_status = ST_IGNORED;
				res_mcode  = eff_marker;
			end
		endcase
	end

	// Walk state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_SOI_A;
			marker_q   <= '0;
			len_hi_q   <= '0;
			rem_q      <= '0;
			prog_q     <= '0;
			matching_q <= 1'b0;
			found_q    <= 1'b0;
			offset_q   <= '0;
		end else if (pop) begin
			phase_q    <= nxt_phase;
			marker_q   <= nxt_marker;
			len_hi_q   <= nxt_len_hi;
			rem_q      <= nxt_rem;
			prog_q     <= nxt_prog;
			matching_q <= nxt_matching;
			found_q    <= nxt_found;
			offset_q   <= nxt_offset;
		end
	end

	// Result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload register.
	always_ff @(posedge clk) begin
		if (pop) begin
			status_q        <= res_status;
			marker_code_q   <= res_mcode;
			byte_value_q    <= b;
			byte_offset_q   <= head_item.pos;
			segment_last_q  <= res_last;
			found_payload_q <= res_fpay;
			found_start_q   <= nxt_found ? nxt_offset : 32'd0;
		end
	end

	assign out_valid          = out_valid_q;
	assign status             = status_q;
	assign marker_code        = marker_code_q;
	assign byte_value         = byte_value_q;
	assign byte_offset        = byte_offset_q;
	assign segment_last       = segment_last_q;
	assign found_payload      = found_payload_q;
	assign found_start_offset = found_start_q;

	`JMSW_NEVER(a_payload_has_bytes, clk, arst_n, phase_q == PH_PAYLOAD && rem_q == 16'd0)
	`JMSW_ASSERT(a_progress_bounded, clk, arst_n, int'(prog_q) <= SIGNATURE_BYTES)
	`JMSW_NEVER(a_found_is_payload, clk, arst_n, out_valid_q && found_payload_q && status_q != ST_PAYLOAD)

endmodule
`default_nettype wire

/* dv/tb_jpeg_marker_segment_walker_top.sv */
// Self-checking testbench for the JPEG marker segment walker against a byte-level predictor.
module tb_jpeg_marker_segment_walker_top;
	timeunit 1ns;
	timeprecision 1ps;
	import jmsw_pkg::*;

	localparam int SIG_BYTES   = 4;
	localparam int HOLD_CYCLES = 300;
	localparam int TAIL_CYCLES = 8;

	// Walk position within the header, as the predictor tracks it.
	typedef enum logic [2:0] {
		WP_SOI_A, WP_SOI_B, WP_PREFIX, WP_CODE, WP_LEN_HI, WP_LEN_LO, WP_PAYLOAD, WP_STOPPED
	} walk_phase_t;

	// Damage that a generated file may carry.
	typedef enum {
		FLT_NONE, FLT_SOI_FIRST, FLT_SOI_SECOND, FLT_PREFIX, FLT_LEN_SHORT, FLT_LEN_LONG
	} file_fault_t;

	typedef struct packed {
		logic [7:0] data;
		logic       first;
	} file_byte_t;

	typedef struct packed {
		status_t     status;
		logic [7:0]  marker;
		logic [7:0]  value;
		logic [31:0] offset;
		logic        last;
		logic        found;
		logic [31:0] found_start;
	} walk_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  data_byte = '0;
	logic        first_of_file = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  status;
	logic [7:0]  marker_code;
	logic [7:0]  byte_value;
	logic [31:0] byte_offset;
	logic        segment_last;
	logic        found_payload;
	logic [31:0] found_start_offset;

	jpeg_marker_segment_walker_top u_top (.*);

	// Register copies and walk state of the predictor.
	logic [31:0] cfg_file_len;
	logic [7:0]  cfg_target;
	logic [31:0] cfg_sig_word;
	logic [2:0]  cfg_sig_len;
	logic [31:0] walk_pos;
	walk_phase_t walk_phase;
	logic [7:0]  walk_marker;
	logic [7:0]  walk_len_hi;
	logic [15:0] walk_left;
	logic [2:0]  walk_sig_prog;
	logic        walk_matching;
	logic        walk_hit;
	logic [31:0] walk_hit_at;

	file_byte_t   stream_bytes[$];
	walk_result_t predicted_results[$];

	logic in_taken = 1'b0;
	logic hold_go = 1'b0;
	logic hold_on = 1'b0;
	int   sender_idle_pct = 0;
	int   receiver_stall_pct = 0;
	int   mismatches = 0;
	int   results_seen = 0;
	int   payload_seen = 0;
	int   found_seen = 0;
	int   bad_seen = 0;
	int   files_sent = 0;
	int   phase_count = 0;
	int   bytes_queued = 0;
	int   gen_pos = 0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic void restart_walk();
		walk_pos = '0;
		walk_phase = WP_SOI_A;
		walk_marker = '0;
		walk_len_hi = '0;
		walk_left = '0;
		walk_sig_prog = '0;
		walk_matching = 1'b0;
		walk_hit = 1'b0;
		walk_hit_at = '0;
	endfunction

	// Signature lengths above the word size saturate.
	function automatic logic [2:0] sig_count();
		return (cfg_sig_len > SIG_BYTES) ? 3'(SIG_BYTES) : cfg_sig_len;
	endfunction

	// Signature byte k, the first one in the high byte of the word.
	function automatic logic [7:0] sig_byte(input logic [2:0] k);
		return 8'(cfg_sig_word >> (8 * (SIG_BYTES - 1 - int'(k))));
	endfunction

	function automatic logic standalone_code(input logic [7:0] c);
		return c == MK_SOI || c == MK_TEM || (c >= MK_RST_FIRST && c <= MK_RST_LAST);
	endfunction

	// Advance the walk by one byte and return the result item it gives.
	function automatic walk_result_t walk_byte(input logic [7:0] b, input logic first);
		walk_result_t r;
		logic [15:0]  seg_len;
		if (first)
			restart_walk();
		r = '{status: ST_STRUCT, marker: 8'h00, value: b, offset: walk_pos,
			last: 1'b0, found: 1'b0, found_start: 32'h0};
		case (walk_phase)
			WP_SOI_A: begin
				r.marker = MK_SOI;
				if (cfg_file_len < MIN_FILE_LEN || b != MK_PREFIX) begin
					r.status = ST_BAD;
					walk_phase = WP_STOPPED;
				end else
					walk_phase = WP_SOI_B;
			end
			WP_SOI_B: begin
				r.marker = MK_SOI;
				if (b != MK_SOI) begin
					r.status = ST_BAD;
					walk_phase = WP_STOPPED;
				end else begin
					walk_marker = MK_SOI;
					walk_phase = WP_PREFIX;
				end
			end
			WP_PREFIX: begin
				// The prefix needs four bytes left in the file.
				if ({1'b0, walk_pos} + 33'd4 > {1'b0, cfg_file_len} || b != MK_PREFIX) begin
					r.status = ST_BAD;
					walk_phase = WP_STOPPED;
				end else
					walk_phase = WP_CODE;
			end
			WP_CODE: begin
				walk_marker = b;
				r.marker = b;
				if (standalone_code(b))
					walk_phase = WP_PREFIX;
				else if (b == MK_SOS || b == MK_EOI) begin
					r.status = ST_END;
					walk_phase = WP_STOPPED;
				end else
					walk_phase = WP_LEN_HI;
			end
			WP_LEN_HI: begin
				r.marker = walk_marker;
				walk_len_hi = b;
				walk_phase = WP_LEN_LO;
			end
			WP_LEN_LO: begin
				r.marker = walk_marker;
				seg_len = {walk_len_hi, b};
				if (seg_len < 16'd2 ||
						{1'b0, walk_pos} - 33'd1 + 33'(seg_len) > {1'b0, cfg_file_len}) begin
					r.status = ST_BAD;
					walk_phase = WP_STOPPED;
				end else begin
					walk_left = seg_len - 16'd2;
					walk_matching = 1'b0;
					walk_sig_prog = '0;
					// Only the first target segment with the signature can match.
					if (!walk_hit && walk_marker == cfg_target) begin
						walk_matching = 1'b1;
						if (sig_count() == 3'd0) begin
							walk_hit = 1'b1;
							walk_hit_at = walk_pos + 32'd1;
						end
					end
					if (walk_left == 16'd0) begin
						walk_matching = 1'b0;
						walk_phase = WP_PREFIX;
					end else
						walk_phase = WP_PAYLOAD;
				end
			end
			WP_PAYLOAD: begin
				r.status = ST_PAYLOAD;
				r.marker = walk_marker;
				if (walk_matching) begin
					if (walk_sig_prog < sig_count()) begin
						if (b != sig_byte(walk_sig_prog))
							walk_matching = 1'b0;
						else begin
							walk_sig_prog++;
							if (walk_sig_prog == sig_count()) begin
								walk_hit = 1'b1;
								walk_hit_at = walk_pos + 32'd1;
							end
						end
					end else
						r.found = 1'b1;
				end
				walk_left--;
				if (walk_left == 16'd0) begin
					r.last = 1'b1;
					walk_matching = 1'b0;
					walk_phase = WP_PREFIX;
				end
			end
			default: begin
				r.status = ST_IGNORED;
				r.marker = walk_marker;
			end
		endcase
		r.found_start = walk_hit ? walk_hit_at : 32'h0;
		walk_pos = walk_pos + 32'd1;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endtask

	// Result checking and prediction of every accepted item.
	always @(posedge clk) begin
		walk_result_t want;
		walk_result_t next_want;
		if (out_valid && !out_stall) begin
			if (predicted_results.size() == 0) begin
				$error("result item at offset %0h with none expected", byte_offset);
				mismatches++;
			end else begin
				want = predicted_results.pop_front();
				check_field("status", want.status, status);
				check_field("marker_code", want.marker, marker_code);
				check_field("byte_value", want.value, byte_value);
				check_field("byte_offset", want.offset, byte_offset);
				check_field("segment_last", want.last, segment_last);
				check_field("found_payload", want.found, found_payload);
				check_field("found_start_offset", want.found_start, found_start_offset);
				results_seen++;
				payload_seen += (want.status == ST_PAYLOAD);
				found_seen += want.found;
				bad_seen += (want.status == ST_BAD);
			end
		end
		if (in_valid && !in_stall) begin
			next_want = walk_byte(data_byte, first_of_file);
			predicted_results.insert(predicted_results.size(), next_want);
		end
		in_taken <= in_valid && !in_stall;
	end

	// Byte driver and receiver stall, both on the falling edge.
	always @(negedge clk) begin
		file_byte_t next_byte;
		if (arst_n && (!in_valid || in_taken)) begin
			if (stream_bytes.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
				next_byte = stream_bytes.pop_front();
				in_valid <= 1'b1;
				data_byte <= next_byte.data;
				first_of_file <= next_byte.first;
			end else
				in_valid <= 1'b0;
		end
		out_stall <= hold_on || ($urandom_range(99) < receiver_stall_pct);
	end

	// Long receiver hold-off, counted here on its own.
	always begin
		wait (hold_go);
		@(posedge clk);
		hold_on = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_on = 1'b0;
		hold_go = 1'b0;
	end

	task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_FILE_LEN:   cfg_file_len = value;
			REG_TARGET:     cfg_target = value[7:0];
			REG_SIG_WORD:   cfg_sig_word = value;
			REG_SIG_LENGTH: cfg_sig_len = value[2:0];
			default:        ;
		endcase
	endtask

	// Wait until every queued byte is in and every result is out.
	task automatic wait_idle();
		while (stream_bytes.size() != 0 || in_valid || predicted_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	function automatic void put_byte(input logic [7:0] b, input logic first);
		file_byte_t nb;
		nb = '{data: b, first: first};
		stream_bytes.insert(stream_bytes.size(), nb);
		gen_pos = first ? 1 : gen_pos + 1;
		bytes_queued++;
	endfunction

	// One generated file: mostly well formed, sometimes damaged at one spot.
	task automatic queue_file(input int room);
		file_fault_t fault;
		int          nseg;
		int          fault_at;
		int          plen;
		int          k;
		logic [7:0]  code;
		logic [7:0]  b;
		logic [15:0] seg_len;
		logic        done;
		case ($urandom_range(19))
			0:       fault = FLT_SOI_FIRST;
			1:       fault = FLT_SOI_SECOND;
			2, 3:    fault = FLT_PREFIX;
			4:       fault = FLT_LEN_SHORT;
			5:       fault = FLT_LEN_LONG;
			default: fault = FLT_NONE;
		endcase
		nseg = $urandom_range(1, 6);
		fault_at = $urandom_range(nseg - 1);
		files_sent++;
		done = 1'b0;
		put_byte((fault == FLT_SOI_FIRST) ? 8'($urandom_range(254)) : MK_PREFIX, 1'b1);
		if (fault == FLT_SOI_FIRST)
			done = 1'b1;
		else begin
			b = 8'($urandom);
			if (b == MK_SOI)
				b = ~b;
			put_byte((fault == FLT_SOI_SECOND) ? b : MK_SOI, 1'b0);
			done = (fault == FLT_SOI_SECOND);
		end
		for (int i = 0; i < nseg && !done; i++) begin
			if (gen_pos + 8 > room)
				break;
			if (fault == FLT_PREFIX && i == fault_at) begin
				put_byte(8'($urandom_range(254)), 1'b0);
				done = 1'b1;
			end else if ($urandom_range(3) == 0) begin
				// Standalone marker: restart, temporary or a second start of image.
				put_byte(MK_PREFIX, 1'b0);
				k = $urandom_range(9);
				code = (k < 8) ? MK_RST_FIRST + 8'(k) : ((k == 8) ? MK_TEM : MK_SOI);
				put_byte(code, 1'b0);
			end else begin
				put_byte(MK_PREFIX, 1'b0);
				code = 8'($urandom);
				if (standalone_code(code) || code == MK_SOS || code == MK_EOI)
					code = 8'hE0 | {4'h0, code[3:0]};
				if ($urandom_range(2) == 0)
					code = cfg_target;
				plen = ($urandom_range(9) == 0) ? $urandom_range(120) : $urandom_range(12);
				if (gen_pos + plen + 9 > room)
					plen = $urandom_range(2);
				seg_len = 16'(plen + 2);
				put_byte(code, 1'b0);
				if (fault == FLT_LEN_LONG && i == fault_at) begin
					// An overlong segment only where it runs past the file length.
					if ({1'b0, cfg_file_len} >= 33'(gen_pos) + 33'h0FFF0)
						seg_len = 16'($urandom_range(1));
					else
						seg_len = 16'hFFFF - 16'($urandom_range(15));
				end else if (fault == FLT_LEN_SHORT && i == fault_at)
					seg_len = 16'($urandom_range(1));
				put_byte(seg_len[15:8], 1'b0);
				put_byte(seg_len[7:0], 1'b0);
				if ((fault == FLT_LEN_LONG || fault == FLT_LEN_SHORT) && i == fault_at)
					done = 1'b1;
				else begin
					k = 0;
					// Target payloads mostly open with the signature, now and then corrupted.
					if (code == cfg_target && $urandom_range(3) != 0) begin
						while (k < int'(sig_count()) && k < plen) begin
							b = sig_byte(3'(k));
							if ($urandom_range(7) == 0)
								b = b ^ (8'd1 << $urandom_range(7));
							put_byte(b, 1'b0);
							k++;
						end
					end
					while (k < plen) begin
						put_byte(8'($urandom), 1'b0);
						k++;
					end
				end
			end
		end
		if (!done && $urandom_range(7) != 0) begin
			put_byte(MK_PREFIX, 1'b0);
			put_byte($urandom_range(1) ? MK_SOS : MK_EOI, 1'b0);
		end
		// Trailing bytes after the generated markers.
		repeat ($urandom_range(2))
			put_byte(8'($urandom), 1'b0);
	endtask

	task automatic queue_files(input int want);
		int goal;
		int room;
		goal = bytes_queued + want;
		while (bytes_queued < goal) begin
			room = (cfg_file_len > 32'd300) ? 300 : int'(cfg_file_len);
			room += $urandom_range(6);
			if ($urandom_range(11) == 0) begin
				// Loose bytes, some of them restarting the walk mid-file.
				repeat ($urandom_range(1, 6))
					put_byte(8'($urandom), $urandom_range(4) == 0);
			end else
				queue_file(room);
		end
	endtask

	task automatic run_phase(input logic [31:0] fsize, input logic [7:0] target,
			input logic [31:0] word, input logic [2:0] slen, input int idle_pct,
			input int stall_pct, input int want);
		wait_idle();
		write_reg(REG_FILE_LEN, fsize);
		write_reg(REG_TARGET, 32'(target));
		write_reg(REG_SIG_WORD, word);
		write_reg(REG_SIG_LENGTH, 32'(slen));
		@(posedge clk);
		sender_idle_pct = idle_pct;
		receiver_stall_pct = stall_pct;
		phase_count++;
		queue_files(want);
	endtask

	// Stimulus: directed files first, then random phases over several settings.
	initial begin
		logic [7:0] intro [22];
		intro = '{MK_PREFIX, MK_SOI, MK_PREFIX, MK_RST_FIRST, MK_PREFIX, MK_TEM,
			MK_PREFIX, MK_SOI, MK_PREFIX, TARGET_RESET, 8'h00, 8'h05, 8'hAA, 8'h55, 8'hC3,
			MK_PREFIX, TARGET_RESET, 8'h00, 8'h02, MK_PREFIX, MK_EOI, 8'h5A};
		restart_walk();
		cfg_file_len = '0;
		cfg_target = TARGET_RESET;
		cfg_sig_word = '0;
		cfg_sig_len = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// File length still zero after reset: the first byte stops the walk.
		@(posedge clk);
		put_byte(MK_PREFIX, 1'b1);
		wait_idle();
		write_reg(REG_FILE_LEN, 32'd48);
		@(posedge clk);
		// Broken start of image, then standalone markers, a matched target
		// segment with an empty signature, an empty segment, the end marker
		// and one ignored byte.
		put_byte(MK_PREFIX, 1'b1);
		put_byte(MK_RST_LAST, 1'b0);
		foreach (intro[i])
			put_byte(intro[i], i == 0);

		run_phase(32'hFFFF_FFFF, TARGET_RESET, 32'h4D50_4600, 3'd4, 0, 0, 250);
		run_phase(32'd200, 8'hFF, 32'hFFFF_FFFF, 3'd7, 79, 0, 250);
		run_phase(32'd0, 8'h00, 32'h0, 3'd0, 14, 14, 20);
		run_phase(32'd64, 8'hC4, $urandom, 3'd1, 14, 14, 250);

		// Receiver holds off while the sender keeps offering items.
		run_phase(32'h8000_0000, 8'hE1, $urandom, 3'd2, 0, 0, 120);
		hold_go = 1'b1;
		// Sender pauses until every result has come back.
		wait_idle();
		@(posedge clk);
		queue_files(130);

		run_phase(32'hFFFF_FFFF, TARGET_RESET, $urandom, 3'd3, 0, 79, 250);

		wait_idle();
		$display("Walked %0d files over %0d register settings, %0d result items checked.",
			files_sent, phase_count + 1, results_seen);
		$display("%0d payload items, %0d flagged after a matched signature, %0d early stops.",
			payload_seen, found_seen, bad_seen);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// Run limit: 10 ms, far beyond the slowest correct run.
	initial begin
		#10_000_000;
		$display("Timed out with %0d results outstanding.", predicted_results.size());
		$display("Mismatches found");
		$finish;
	end

endmodule

/* sim.f */
+incdir+hdl
hdl/jmsw_pkg.sv
hdl/jmsw_front.sv
hdl/jmsw_fifo.sv
hdl/jmsw_back.sv
hdl/jpeg_marker_segment_walker_top.sv
dv/tb_jpeg_marker_segment_walker_top.sv
